@@ src/dnm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnm_pkg
// Shared types and constants of the descriptor nearest-match block.
// ----------------------------------------------------------------------------
package dnm_pkg;

  // descriptor element and chunk geometry
  localparam int ELEM_W          = 8;
  localparam int ELEMS_PER_CHUNK = 8;
  localparam int WORD_W          = ELEM_W * ELEMS_PER_CHUNK;

  // squared element difference
  localparam int SQ_W   = 16;
  localparam int SQ_MAX = 65025;

  // distance and configuration widths
  localparam int                DIST_W       = 23;
  localparam logic [DIST_W-1:0] DIST_MAX     = 23'h7FFFFF;
  localparam int                COUNT_W      = 9;
  localparam logic [DIST_W-1:0] THRESH_RESET = 23'd8323201;
  localparam int                CFG_INDEX_W  = 1;
  localparam int                CFG_DATA_W   = 23;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DICT_COUNT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_THRESH = 1'b1;

  // transaction modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } dnm_state_t;

  // control tag that travels with each beat through the datapath
  typedef struct packed {
    logic valid;  // beat carries real element data
    logic first;  // first beat of an entry, restarts the accumulator
    logic last;   // last beat of an entry, distance is complete
    logic clear;  // first beat of a query, resets the best-so-far
    logic done;   // final beat of a query, result goes out
  } dnm_beat_t;

endpackage
`default_nettype wire

@@ src/descriptor_nearest_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_nearest_match
// Dictionary of feature descriptors with a nearest-match search by squared
// Euclidean distance against a query loaded chunk by chunk.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   --------  -------------------  -------------------------------------------
//   input     start && !busy       mode, entry_index, chunk_index, chunk_data
//   result    done (one cycle)     matched, best_index, best_distance
//   config    cfg_we               cfg_index, cfg_data
//
// A load chunk or a query chunk other than the last only writes its RAM.
// The last query chunk starts a scan of the first count entries, word by
// word from the dictionary RAM, each word split into steps over the lanes;
// the RAM read, lane squares, lane sum, accumulator and result are registered;
// busy is high until the result. An empty dictionary sends one tag-only beat.
// rst is synchronous; it clears the sequencer, the pipeline tags and the
// configuration registers, not the dictionary or query RAM.
// The done strobe is shown for one cycle; the payload holds until the next result.
// ----------------------------------------------------------------------------
module descriptor_nearest_match #(
  parameter int DICT_ENTRIES      = 256,
  parameter int DESCRIPTOR_LENGTH = 128,
  parameter int LANES             = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                mode,
  input  wire logic [7:0]                          entry_index,
  input  wire logic [3:0]                          chunk_index,
  input  wire logic [dnm_pkg::WORD_W-1:0]          chunk_data,
  output logic                                     done,
  output logic                                     matched,
  output logic      [7:0]                          best_index,
  output logic      [dnm_pkg::DIST_W-1:0]          best_distance,
  input  wire logic                                cfg_we,
  input  wire logic [dnm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [dnm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dnm_pkg::*;

  localparam int CHUNKS  = DESCRIPTOR_LENGTH / ELEMS_PER_CHUNK;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IDX_W   = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int DEPTH   = DICT_ENTRIES * CHUNKS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STEPS   = (ELEMS_PER_CHUNK + LANES - 1) / LANES;
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W   = ($clog2(DICT_ENTRIES + 1) > COUNT_W) ?
                           $clog2(DICT_ENTRIES + 1) : COUNT_W;

  // configuration registers
  logic [COUNT_W-1:0] dictionary_count;
  logic [DIST_W-1:0]  match_threshold;

  // sequencer
  dnm_state_t         state;
  dnm_state_t         state_next;
  logic [IDX_W-1:0]   entry_cnt;
  logic [IDX_W-1:0]   entry_cnt_next;
  logic [CHUNK_W-1:0] chunk_cnt;
  logic [CHUNK_W-1:0] chunk_cnt_next;
  logic [STEP_W-1:0]  step_cnt;
  logic [STEP_W-1:0]  step_cnt_next;
  logic [IDX_W-1:0]   last_entry;
  logic [IDX_W-1:0]   last_entry_next;
  dnm_beat_t          beat;
  dnm_beat_t          beat_r1;
  logic [STEP_W-1:0]  step_r1;

  // input decode
  logic               accept;
  logic               chunk_ok;
  logic               entry_ok;
  logic               load_we;
  logic               query_we;
  logic               trigger;
  logic [CNT_W-1:0]   count_ext;
  logic [CNT_W-1:0]   count_eff;
  logic               step_last;
  logic               chunk_last;
  logic               entry_last;

  // memories
  logic [ADDR_W-1:0]  dict_waddr;
  logic [ADDR_W-1:0]  dict_raddr;
  logic [WORD_W-1:0]  dict_word;
  logic [WORD_W-1:0]  query_word;
  logic [LANES-1:0][SQ_W-1:0] sq;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dictionary_count <= '0;
      match_threshold  <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DICT_COUNT:   dictionary_count <= cfg_data[COUNT_W-1:0];
        CFG_MATCH_THRESH: match_threshold  <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // transaction decode
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign chunk_ok = (32'(chunk_index) < CHUNKS);
  assign entry_ok = (32'(entry_index) < DICT_ENTRIES);
  assign load_we  = accept && (mode == MODE_LOAD) && chunk_ok && entry_ok;
  assign query_we = accept && (mode == MODE_QUERY) && chunk_ok;
  assign trigger  = query_we && (32'(chunk_index) == CHUNKS - 1);

  // entries searched, limited to the dictionary size
  assign count_ext = CNT_W'(dictionary_count);
  assign count_eff = (count_ext > CNT_W'(DICT_ENTRIES)) ? CNT_W'(DICT_ENTRIES) : count_ext;

  assign step_last  = (step_cnt == STEP_W'(STEPS - 1));
  assign chunk_last = (chunk_cnt == CHUNK_W'(CHUNKS - 1));
  assign entry_last = (entry_cnt == last_entry);

  // sequencer next state and beat issue
  always_comb begin
    state_next      = state;
    entry_cnt_next  = entry_cnt;
    chunk_cnt_next  = chunk_cnt;
    step_cnt_next   = step_cnt;
    last_entry_next = last_entry;
    beat            = '0;
    case (state)
      S_IDLE: begin
        if (trigger) begin
          entry_cnt_next  = '0;
          chunk_cnt_next  = '0;
          step_cnt_next   = '0;
          last_entry_next = IDX_W'(count_eff - CNT_W'(1));
          if (count_eff == '0) begin
            // empty dictionary: one tag-only beat carries the default answer
            beat.clear = 1'b1;
            beat.done  = 1'b1;
            state_next = S_FLUSH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        beat.valid = 1'b1;
        beat.first = (step_cnt == '0) && (chunk_cnt == '0);
        beat.last  = step_last && chunk_last;
        beat.clear = beat.first && (entry_cnt == '0);
        beat.done  = beat.last && entry_last;
        if (step_last) begin
          step_cnt_next = '0;
          if (chunk_last) begin
            chunk_cnt_next = '0;
            entry_cnt_next = entry_cnt + IDX_W'(1);
          end else begin
            chunk_cnt_next = chunk_cnt + CHUNK_W'(1);
          end
        end else begin
          step_cnt_next = step_cnt + STEP_W'(1);
        end
        if (beat.done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    entry_cnt  <= entry_cnt_next;
    chunk_cnt  <= chunk_cnt_next;
    step_cnt   <= step_cnt_next;
    last_entry <= last_entry_next;
  end

  // tag aligned with the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_r1 <= '0;
    end else begin
      beat_r1 <= beat;
    end
  end

  always_ff @(posedge clk) begin
    step_r1 <= step_cnt;
  end

  // dictionary word addresses
  assign dict_waddr = ADDR_W'(entry_index) * ADDR_W'(CHUNKS) + ADDR_W'(chunk_index);
  assign dict_raddr = ADDR_W'(entry_cnt) * ADDR_W'(CHUNKS) + ADDR_W'(chunk_cnt);

  dnm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_dict_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (dict_waddr),
    .wdata (chunk_data),
    .raddr (dict_raddr),
    .rdata (dict_word)
  );

  dnm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHUNKS),
    .AW    (CHUNK_W)
  ) u_query_ram (
    .clk   (clk),
    .we    (query_we),
    .waddr (CHUNK_W'(chunk_index)),
    .wdata (chunk_data),
    .raddr (chunk_cnt),
    .rdata (query_word)
  );

  // distance lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dnm_lane #(
      .LANES  (LANES),
      .LANE   (l),
      .STEPS  (STEPS),
      .STEP_W (STEP_W)
    ) u_lane (
      .clk    (clk),
      .step   (step_r1),
      .q_word (query_word),
      .d_word (dict_word),
      .sq     (sq[l])
    );
  end

  // merge lanes and pick the best entry
  dnm_merge #(
    .LANES             (LANES),
    .DESCRIPTOR_LENGTH (DESCRIPTOR_LENGTH),
    .IDX_W             (IDX_W)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .beat_in         (beat_r1),
    .sq              (sq),
    .match_threshold (match_threshold),
    .done            (done),
    .matched         (matched),
    .best_index      (best_index),
    .best_distance   (best_distance)
  );

endmodule
`default_nettype wire

@@ src/dnm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dnm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/dnm_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnm_lane
// One distance lane: picks its element of the query and dictionary words for
// the current step and registers the squared difference.
// ----------------------------------------------------------------------------
module dnm_lane #(
  parameter int LANES  = 8,
  parameter int LANE   = 0,
  parameter int STEPS  = (8 + LANES - 1) / LANES,
  parameter int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1
) (
  input  wire logic                          clk,
  input  wire logic [STEP_W-1:0]             step,
  input  wire logic [dnm_pkg::WORD_W-1:0]    q_word,
  input  wire logic [dnm_pkg::WORD_W-1:0]    d_word,
  output logic      [dnm_pkg::SQ_W-1:0]      sq
);
  import dnm_pkg::*;

  logic [ELEM_W-1:0] a;
  logic [ELEM_W-1:0] b;
  logic              use_elem;
  logic [ELEM_W:0]   diff;
  logic [ELEM_W:0]   neg;
  logic [ELEM_W-1:0] mag;

  // element select for this lane and step
  always_comb begin
    a        = '0;
    b        = '0;
    use_elem = 1'b0;
    for (int s = 0; s < STEPS; s++) begin
      if (STEP_W'(s) == step && (s * LANES + LANE) < ELEMS_PER_CHUNK) begin
        a        = q_word[(s * LANES + LANE) * ELEM_W +: ELEM_W];
        b        = d_word[(s * LANES + LANE) * ELEM_W +: ELEM_W];
        use_elem = 1'b1;
      end
    end
  end

  // absolute difference
  assign diff = {1'b0, a} - {1'b0, b};
  assign neg  = ~diff + 1'b1;
  assign mag  = diff[ELEM_W] ? neg[ELEM_W-1:0] : diff[ELEM_W-1:0];

  // registered square, zero for a lane with no element in this step
  always_ff @(posedge clk) begin
    sq <= use_elem ? SQ_W'(mag) * SQ_W'(mag) : '0;
  end

endmodule
`default_nettype wire

@@ src/dnm_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnm_merge
// Merging stage: sums the lane squares, accumulates each entry's distance,
// keeps the first strictly smallest distance and issues the query result.
// ----------------------------------------------------------------------------
module dnm_merge #(
  parameter int LANES             = 8,
  parameter int DESCRIPTOR_LENGTH = 128,
  parameter int IDX_W             = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dnm_pkg::dnm_beat_t                   beat_in,
  input  wire logic [LANES-1:0][dnm_pkg::SQ_W-1:0]  sq,
  input  wire logic [dnm_pkg::DIST_W-1:0]           match_threshold,
  output logic                                      done,
  output logic                                      matched,
  output logic      [7:0]                           best_index,
  output logic      [dnm_pkg::DIST_W-1:0]           best_distance
);
  import dnm_pkg::*;

  localparam int SUM_W = $clog2(LANES * SQ_MAX + 1);
  localparam int ACC_W = $clog2(DESCRIPTOR_LENGTH * SQ_MAX + 1);

  dnm_beat_t         beat_s2;
  dnm_beat_t         beat_s3;
  dnm_beat_t         beat_s4;
  logic [SUM_W-1:0]  sum_comb;
  logic [SUM_W-1:0]  sum_s3;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;

  logic              have_any;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  entry_cnt;

  logic              base_have;
  logic [DIST_W-1:0] base_dist;
  logic [IDX_W-1:0]  base_idx;
  logic [IDX_W-1:0]  base_cnt;
  logic [ACC_W+DIST_W-1:0] acc_wide;
  logic [DIST_W-1:0] dist_sat;
  logic              entry_end;
  logic              upd;
  logic              have_next;
  logic [DIST_W-1:0] dist_next;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W+7:0]  idx_wide;

  // control tags follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_s2 <= '0;
      beat_s3 <= '0;
      beat_s4 <= '0;
    end else begin
      beat_s2 <= beat_in;
      beat_s3 <= beat_s2;
      beat_s4 <= beat_s3;
    end
  end

  // lane sum
  always_comb begin
    sum_comb = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_comb = sum_comb + SUM_W'(sq[l]);
    end
  end

  always_ff @(posedge clk) begin
    sum_s3 <= sum_comb;
  end

  // per-entry accumulator
  always_comb begin
    acc_next = acc;
    if (beat_s3.valid) begin
      acc_next = beat_s3.first ? ACC_W'(sum_s3) : acc + ACC_W'(sum_s3);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // best-so-far compare, a new query starts from the empty answer
  always_comb begin
    base_have = beat_s4.clear ? 1'b0     : have_any;
    base_dist = beat_s4.clear ? DIST_MAX : best_dist;
    base_idx  = beat_s4.clear ? '0       : best_idx;
    base_cnt  = beat_s4.clear ? '0       : entry_cnt;
    acc_wide  = {{DIST_W{1'b0}}, acc};
    dist_sat  = (acc_wide > (ACC_W + DIST_W)'(DIST_MAX)) ? DIST_MAX : acc_wide[DIST_W-1:0];
    entry_end = beat_s4.valid && beat_s4.last;
    upd       = entry_end && (!base_have || dist_sat < base_dist);
    have_next = base_have | entry_end;
    dist_next = upd ? dist_sat : base_dist;
    idx_next  = upd ? base_cnt : base_idx;
    idx_wide  = {8'b0, idx_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_any  <= 1'b0;
      best_dist <= DIST_MAX;
      best_idx  <= '0;
      entry_cnt <= '0;
    end else begin
      have_any  <= have_next;
      best_dist <= dist_next;
      best_idx  <= idx_next;
      entry_cnt <= base_cnt + IDX_W'(entry_end);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= beat_s4.done;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (beat_s4.done) begin
      matched       <= have_next && (dist_next < match_threshold);
      best_index    <= idx_wide[7:0];
      best_distance <= dist_next;
    end
  end

endmodule
`default_nettype wire

@@ src/dnm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnm_checker
// Port-level checks of the descriptor nearest-match block, bound to the top.
// ----------------------------------------------------------------------------
module dnm_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          mode,
  input  wire logic                          done,
  input  wire logic                          matched,
  input  wire logic [dnm_pkg::DIST_W-1:0]    best_distance
);
  import dnm_pkg::*;

  // a result only comes at the end of a search
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a search in progress");

  // the result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a search starts only from an accepted query transaction
  a_busy_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && mode == MODE_QUERY))
    else $error("busy without a query transaction");

  // the saturated distance never matches
  a_no_match_at_max: assert property (@(posedge clk) disable iff (rst)
    (done && best_distance == DIST_MAX) |-> !matched)
    else $error("match reported at maximum distance");

endmodule

bind descriptor_nearest_match dnm_checker u_dnm_checker (.*);
`default_nettype wire
